/* rtl/core/bfla_pkg.sv */
`timescale 1ns / 1ps

package bfla_pkg;

    // Default sizing
    localparam int POOL_MAX_DEF = 65536;
    localparam int ALIGN_DEF    = 8;
    localparam int HEAD_DEF     = 16;

    // Command codes
    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_ALLOC  = 2'd1;
    localparam logic [1:0] CMD_FREE   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_FREEFAIL = 2'd3;

    // Configuration register indexes
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_POOL = 1'b1;

    // Header read address sources
    localparam logic [2:0] RA_ZERO  = 3'd0;
    localparam logic [2:0] RA_RNEXT = 3'd1;
    localparam logic [2:0] RA_BNEXT = 3'd2;
    localparam logic [2:0] RA_OFF   = 3'd3;
    localparam logic [2:0] RA_RPREV = 3'd4;
    localparam logic [2:0] RA_CNEXT = 3'd5;

    // Header write sources
    localparam logic [2:0] WR_HEAD = 3'd0;
    localparam logic [2:0] WR_TAIL = 3'd1;
    localparam logic [2:0] WR_APRE = 3'd2;
    localparam logic [2:0] WR_ANXT = 3'd3;
    localparam logic [2:0] WR_ANEW = 3'd4;
    localparam logic [2:0] WR_FPRE = 3'd5;
    localparam logic [2:0] WR_FNXT = 3'd6;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       wr_en;
        logic [2:0] wr_sel;
        logic       walk_init;
        logic       walk_eval;
        logic       cap_c;
        logic       cap_pre;
        logic       cap_nxt;
        logic       set_ready;
        logic       respond;
        logic [1:0] resp_status;
    } bfla_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] command;
        logic       create_ok;
        logic       alloc_ok;
        logic       pool_ready;
        logic       range_ok;
        logic       next_none;
        logic       link_hit;
        logic       found;
        logic       c_bad;
    } bfla_stat_t;

endpackage

/* rtl/core/bfla_datapath.sv */
`timescale 1ns / 1ps

module bfla_datapath #(
    parameter int POOL_MAX_BYTES = bfla_pkg::POOL_MAX_DEF,
    parameter int ALIGN_BYTES    = bfla_pkg::ALIGN_DEF,
    parameter int HEAD_BYTES     = bfla_pkg::HEAD_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfla_pkg::bfla_cmd_t  cmd,
    output bfla_pkg::bfla_stat_t stat,
    input  logic [1:0]           command,
    input  logic [16:0]          request_bytes,
    input  logic [31:0]          payload_address,
    input  logic                 cfg_wr,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 done,
    output logic [1:0]           status,
    output logic [31:0]          granted_address
);
    import bfla_pkg::*;

    localparam int OFF_W = $clog2(POOL_MAX_BYTES);
    localparam int DEPTH = POOL_MAX_BYTES / ALIGN_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HW    = 3 * OFF_W;
    localparam int GW    = (OFF_W + 2 > 19) ? OFF_W + 2 : 19;
    localparam logic [OFF_W-1:0] NONE     = '1;
    localparam logic [OFF_W-1:0] HEAD_OFF = OFF_W'(HEAD_BYTES);

    // Header layout: {prev, next, len}
    function automatic logic [OFF_W-1:0] hprev(input logic [HW-1:0] h);
        hprev = h[HW-1 -: OFF_W];
    endfunction
    function automatic logic [OFF_W-1:0] hnext(input logic [HW-1:0] h);
        hnext = h[2*OFF_W-1 -: OFF_W];
    endfunction
    function automatic logic [OFF_W-1:0] hlen(input logic [HW-1:0] h);
        hlen = h[OFF_W-1:0];
    endfunction

    logic [31:0]      base_reg;
    logic [16:0]      pool_reg;
    logic             pool_ready_reg;
    logic [1:0]       cmd_reg;
    logic [16:0]      req_reg;
    logic [31:0]      addr_reg;
    logic [OFF_W-1:0] cur_off_reg;
    logic [GW-1:0]    best_gap_reg;
    logic             found_reg;
    logic [OFF_W-1:0] best_off_reg;
    logic [HW-1:0]    bhdr_reg;
    logic [HW-1:0]    c_reg;
    logic [HW-1:0]    pre_reg;
    logic [HW-1:0]    nxt_reg;
    logic [HW-1:0]    mem [DEPTH];
    logic [HW-1:0]    mem_q_reg;
    logic             roor_reg;
    logic             done_reg;
    logic [1:0]       status_reg;
    logic [31:0]      grant_reg;

    logic [HW-1:0]    rdata;
    logic [GW-1:0]    need;
    logic [GW-1:0]    cur_end;
    logic [GW-1:0]    nxt_w;
    logic [GW-1:0]    gap;
    logic             fit;
    logic [OFF_W-1:0] new_off;
    logic [33:0]      off_w;
    logic [OFF_W-1:0] free_off;
    logic [OFF_W-1:0] tail_off;
    logic [OFF_W-1:0] rd_off;
    logic [OFF_W-1:0] rd_idx;
    logic [OFF_W-1:0] wr_off;
    logic [OFF_W-1:0] wr_idx;
    logic [HW-1:0]    wr_hdr;
    logic             rd_in;
    logic             wr_in;

    // Header read data, out-of-store reads return zero
    assign rdata = roor_reg ? '0 : mem_q_reg;

    // Gap behind the current block and best-fit test
    assign need    = GW'(req_reg) + GW'(HEAD_BYTES);
    assign cur_end = GW'(cur_off_reg) + GW'(hlen(rdata));
    assign nxt_w   = GW'(hnext(rdata));
    assign gap     = (nxt_w >= cur_end) ? (nxt_w - cur_end) : '0;
    assign fit     = (need <= gap) && (!found_reg || (best_gap_reg > gap));
    assign new_off = best_off_reg + hlen(bhdr_reg);

    // Free offset and create sentinel
    assign off_w    = {2'b00, addr_reg} - {2'b00, base_reg} - 34'(HEAD_BYTES);
    assign free_off = off_w[OFF_W-1:0];
    assign tail_off = OFF_W'(17'(pool_reg - 17'(HEAD_BYTES)));

    // Status to controller
    always_comb
    begin
        stat.command    = cmd_reg;
        stat.create_ok  = ((pool_reg % ALIGN_BYTES) == 0)
                          && (32'(pool_reg) >= 32'(2 * HEAD_BYTES))
                          && (32'(pool_reg) <= 32'(POOL_MAX_BYTES));
        stat.alloc_ok   = pool_ready_reg && ((req_reg % ALIGN_BYTES) == 0);
        stat.pool_ready = pool_ready_reg;
        stat.range_ok   = !(({2'b00, addr_reg} < ({2'b00, base_reg} + 34'(HEAD_BYTES)))
                          || (({2'b00, addr_reg} + 34'(HEAD_BYTES))
                              > ({2'b00, base_reg} + 34'(pool_reg))));
        stat.next_none  = (hnext(rdata) == NONE);
        stat.link_hit   = (hnext(rdata) != NONE) && (34'(hnext(rdata)) == off_w);
        stat.found      = found_reg;
        stat.c_bad      = (hprev(rdata) == NONE) || (hnext(rdata) == NONE);
    end

    // Read address select
    always_comb
    begin
        case (cmd.rd_sel)
            RA_ZERO:  rd_off = '0;
            RA_RNEXT: rd_off = hnext(rdata);
            RA_BNEXT: rd_off = hnext(bhdr_reg);
            RA_OFF:   rd_off = free_off;
            RA_RPREV: rd_off = hprev(rdata);
            RA_CNEXT: rd_off = hnext(c_reg);
            default:  rd_off = '0;
        endcase
    end

    // Write address and header select
    always_comb
    begin
        case (cmd.wr_sel)
            WR_HEAD:
            begin
                wr_off = '0;
                wr_hdr = {NONE, tail_off, HEAD_OFF};
            end
            WR_TAIL:
            begin
                wr_off = tail_off;
                wr_hdr = {{OFF_W{1'b0}}, NONE, HEAD_OFF};
            end
            WR_APRE:
            begin
                wr_off = best_off_reg;
                wr_hdr = {hprev(bhdr_reg), new_off, hlen(bhdr_reg)};
            end
            WR_ANXT:
            begin
                wr_off = hnext(bhdr_reg);
                wr_hdr = {new_off, hnext(nxt_reg), hlen(nxt_reg)};
            end
            WR_ANEW:
            begin
                wr_off = new_off;
                wr_hdr = {best_off_reg, hnext(bhdr_reg), need[OFF_W-1:0]};
            end
            WR_FPRE:
            begin
                wr_off = hprev(c_reg);
                wr_hdr = {hprev(pre_reg), hnext(c_reg), hlen(pre_reg)};
            end
            WR_FNXT:
            begin
                wr_off = hnext(c_reg);
                wr_hdr = {hprev(c_reg), hnext(nxt_reg), hlen(nxt_reg)};
            end
            default:
            begin
                wr_off = '0;
                wr_hdr = '0;
            end
        endcase
    end

    assign rd_idx = OFF_W'(rd_off / ALIGN_BYTES);
    assign wr_idx = OFF_W'(wr_off / ALIGN_BYTES);
    assign rd_in  = (32'(rd_idx) < 32'(DEPTH));
    assign wr_in  = (32'(wr_idx) < 32'(DEPTH));

    // Header store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_in)
        begin
            mem[wr_idx[AW-1:0]] <= wr_hdr;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[rd_idx[AW-1:0]];
            roor_reg  <= !rd_in;
        end
    end

    // Control state: config, pool flag, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            pool_reg       <= 17'h10000;
            pool_ready_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (cfg_index == CFG_BASE))
            begin
                base_reg <= cfg_data;
            end
            if (cfg_wr && (cfg_index == CFG_POOL))
            begin
                pool_reg <= cfg_data[16:0];
            end
            if (cmd.set_ready)
            begin
                pool_ready_reg <= 1'b1;
            end
            done_reg <= cmd.respond;
        end
    end

    // Item, walk and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= command;
            req_reg  <= request_bytes;
            addr_reg <= payload_address;
        end
        if (cmd.walk_init)
        begin
            cur_off_reg <= '0;
            found_reg   <= 1'b0;
        end
        if (cmd.walk_eval)
        begin
            if (fit)
            begin
                best_gap_reg <= gap;
                best_off_reg <= cur_off_reg;
                bhdr_reg     <= rdata;
                found_reg    <= 1'b1;
            end
            cur_off_reg <= hnext(rdata);
        end
        if (cmd.cap_c)
        begin
            c_reg <= rdata;
        end
        if (cmd.cap_pre)
        begin
            pre_reg <= rdata;
        end
        if (cmd.cap_nxt)
        begin
            nxt_reg <= rdata;
        end
        if (cmd.respond)
        begin
            status_reg <= cmd.resp_status;
            if ((cmd.resp_status == ST_OK) && (cmd_reg == CMD_ALLOC))
            begin
                grant_reg <= base_reg + 32'(new_off) + 32'(HEAD_BYTES);
            end
            else
            begin
                grant_reg <= '0;
            end
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_address = grant_reg;

endmodule

/* rtl/core/bfla_ctrl.sv */
`timescale 1ns / 1ps

module bfla_ctrl #(
    parameter int DEPTH = bfla_pkg::POOL_MAX_DEF / bfla_pkg::ALIGN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bfla_pkg::bfla_stat_t stat,
    output bfla_pkg::bfla_cmd_t  cmd
);
    import bfla_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 3);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(DEPTH + 2);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_CWT   = 4'd2;
    localparam logic [3:0] S_AWALK = 4'd3;
    localparam logic [3:0] S_AWPRE = 4'd4;
    localparam logic [3:0] S_AWNXT = 4'd5;
    localparam logic [3:0] S_AWNEW = 4'd6;
    localparam logic [3:0] S_FWALK = 4'd7;
    localparam logic [3:0] S_FRDP  = 4'd8;
    localparam logic [3:0] S_FRDN  = 4'd9;
    localparam logic [3:0] S_FWPRE = 4'd10;
    localparam logic [3:0] S_FWNXT = 4'd11;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                state_next = S_IDLE;
                case (stat.command)
                    CMD_CREATE:
                    begin
                        if (stat.create_ok)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WR_HEAD;
                            state_next = S_CWT;
                        end
                        else
                        begin
                            cmd.respond     = 1'b1;
                            cmd.resp_status = ST_INVALID;
                        end
                    end
                    CMD_ALLOC:
                    begin
                        if (stat.alloc_ok)
                        begin
                            cmd.rd_en     = 1'b1;
                            cmd.rd_sel    = RA_ZERO;
                            cmd.walk_init = 1'b1;
                            cnt_next      = '0;
                            state_next    = S_AWALK;
                        end
                        else
                        begin
                            cmd.respond     = 1'b1;
                            cmd.resp_status = ST_INVALID;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (!stat.pool_ready)
                        begin
                            cmd.respond     = 1'b1;
                            cmd.resp_status = ST_INVALID;
                        end
                        else if (!stat.range_ok)
                        begin
                            cmd.respond     = 1'b1;
                            cmd.resp_status = ST_FREEFAIL;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_ZERO;
                            cnt_next   = '0;
                            state_next = S_FWALK;
                        end
                    end
                    default:
                    begin
                        cmd.respond     = 1'b1;
                        cmd.resp_status = ST_INVALID;
                    end
                endcase
            end
            S_CWT:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_sel      = WR_TAIL;
                cmd.set_ready   = 1'b1;
                cmd.respond     = 1'b1;
                cmd.resp_status = ST_OK;
                state_next      = S_IDLE;
            end
            // Allocate: one header per cycle
            S_AWALK:
            begin
                if (stat.next_none || (cnt_reg == LIMIT))
                begin
                    if (stat.found)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_BNEXT;
                        state_next = S_AWPRE;
                    end
                    else
                    begin
                        cmd.respond     = 1'b1;
                        cmd.resp_status = ST_NOSPACE;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.walk_eval = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = RA_RNEXT;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            S_AWPRE:
            begin
                cmd.cap_nxt = 1'b1;
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_APRE;
                state_next  = S_AWNXT;
            end
            S_AWNXT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_ANXT;
                state_next = S_AWNEW;
            end
            S_AWNEW:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_sel      = WR_ANEW;
                cmd.respond     = 1'b1;
                cmd.resp_status = ST_OK;
                state_next      = S_IDLE;
            end
            // Free: search for a link to the offset
            S_FWALK:
            begin
                if (cnt_reg == LIMIT)
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = ST_FREEFAIL;
                    state_next      = S_IDLE;
                end
                else if (stat.link_hit)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_OFF;
                    state_next = S_FRDP;
                end
                else if (stat.next_none)
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = ST_FREEFAIL;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_RNEXT;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            S_FRDP:
            begin
                cmd.cap_c = 1'b1;
                if (stat.c_bad)
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = ST_FREEFAIL;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_RPREV;
                    state_next = S_FRDN;
                end
            end
            S_FRDN:
            begin
                cmd.cap_pre = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RA_CNEXT;
                state_next  = S_FWPRE;
            end
            S_FWPRE:
            begin
                cmd.cap_nxt = 1'b1;
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_FPRE;
                state_next  = S_FWNXT;
            end
            S_FWNXT:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_sel      = WR_FNXT;
                cmd.respond     = 1'b1;
                cmd.resp_status = ST_OK;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Every item ends back in idle right after its result
    a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |=> (state_reg == S_IDLE))
        else $error("controller not idle after result");

    // No header write while idle
    a_idle_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !cmd.wr_en)
        else $error("header write in idle");

    // Walk count stays within the bound
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LIMIT)
        else $error("walk counter overrun");

    // Accepted item goes to the check state
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (state_reg == S_IDLE)) |=> (state_reg == S_CHK))
        else $error("accepted item not checked");

endmodule

/* rtl/core/best_fit_list_allocator.sv */
`timescale 1ns / 1ps
// The walk reads one header per cycle through the single header store read port.
// Result strobe (done) appears the cycle after the last state; busy drops then too.
// One item at a time; the receiver cannot stall the result.
// Reset: pool not created, base_address 0, pool_size 65536; header store undefined.
module best_fit_list_allocator #(
    parameter int POOL_MAX_BYTES = bfla_pkg::POOL_MAX_DEF,
    parameter int ALIGN_BYTES    = bfla_pkg::ALIGN_DEF,
    parameter int HEAD_BYTES     = bfla_pkg::HEAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [16:0] request_bytes,
    input  logic [31:0] payload_address,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] granted_address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import bfla_pkg::*;

    localparam int DEPTH = POOL_MAX_BYTES / ALIGN_BYTES;

    bfla_cmd_t  cmd;
    bfla_stat_t stat;

    assign cfg_ready = 1'b1;

    bfla_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    bfla_datapath #(
        .POOL_MAX_BYTES(POOL_MAX_BYTES),
        .ALIGN_BYTES   (ALIGN_BYTES),
        .HEAD_BYTES    (HEAD_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .command         (command),
        .request_bytes   (request_bytes),
        .payload_address (payload_address),
        .cfg_wr          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .status          (status),
        .granted_address (granted_address)
    );

endmodule

/* verif/best_fit_list_allocator_tb.sv */
`timescale 1ns / 1ps

// Holds the expected outcome of each item and a copy of the header list state
class alloc_scoreboard;
    localparam bit [31:0] NONE      = 32'hFFFF_FFFF;
    localparam int        ALIGN     = bfla_pkg::ALIGN_DEF;
    localparam int        HEAD      = bfla_pkg::HEAD_DEF;
    localparam int        POOL_MAX  = bfla_pkg::POOL_MAX_DEF;
    localparam int        DEPTH     = POOL_MAX / ALIGN;

    typedef struct {
        bit [31:0] prev;
        bit [31:0] next;
        bit [31:0] len;
    } hdr_t;

    hdr_t      headers [DEPTH];
    bit [31:0] pool_base;
    bit [16:0] pool_bytes;
    bit        pool_up;
    bit [1:0]  status_q [$];
    bit [31:0] grant_q [$];
    int        errors;
    int        checked;

    function new();
        pool_base  = 0;
        pool_bytes = 17'd65536;
        pool_up    = 0;
        errors     = 0;
        checked    = 0;
    endfunction

    function void set_reg(logic idx, bit [31:0] val);
        if (idx == bfla_pkg::CFG_BASE)
            pool_base = val;
        else
            pool_bytes = val[16:0];
    endfunction

    function hdr_t rd(bit [31:0] off);
        hdr_t z;
        z = '{0, 0, 0};
        if (off / ALIGN >= DEPTH)
            return z;
        return headers[off / ALIGN];
    endfunction

    function void wr(bit [31:0] off, hdr_t h);
        if (off / ALIGN < DEPTH)
            headers[off / ALIGN] = h;
    endfunction

    function bit [1:0] create_pool();
        hdr_t h;
        if (pool_bytes % ALIGN != 0 || pool_bytes < 2 * HEAD || pool_bytes > POOL_MAX)
            return bfla_pkg::ST_INVALID;
        h = '{NONE, 32'(pool_bytes - HEAD), HEAD};
        wr(0, h);
        h = '{0, NONE, HEAD};
        wr(32'(pool_bytes - HEAD), h);
        pool_up = 1;
        return bfla_pkg::ST_OK;
    endfunction

    function bit [1:0] best_fit(bit [16:0] req, output bit [31:0] grant);
        bit [31:0] cur_off, best_pre, new_off, nxt_off;
        longint    best, need, gap, fin;
        int        steps;
        bit        found;
        hdr_t      cur, pre, nxt, nw;
        grant = 0;
        if (!pool_up || req % ALIGN != 0)
            return bfla_pkg::ST_INVALID;
        need    = longint'(req) + HEAD;
        cur_off = 0;
        best_pre = 0;
        best    = 0;
        found   = 0;
        steps   = 0;
        cur     = rd(0);
        while (cur.next != NONE && steps < DEPTH + 2) begin
            fin = longint'(cur_off) + cur.len;
            gap = (longint'(cur.next) >= fin) ? longint'(cur.next) - fin : 0;
            if (need <= gap && (!found || best > gap)) begin
                best     = gap;
                best_pre = cur_off;
                found    = 1;
            end
            cur_off = cur.next;
            cur     = rd(cur_off);
            steps++;
        end
        if (!found)
            return bfla_pkg::ST_NOSPACE;
        pre     = rd(best_pre);
        nxt_off = pre.next;
        nxt     = rd(nxt_off);
        new_off = best_pre + pre.len;
        nw      = '{best_pre, nxt_off, 32'(need)};
        pre.next = new_off;
        nxt.prev = new_off;
        wr(best_pre, pre);
        wr(nxt_off, nxt);
        wr(new_off, nw);
        grant = pool_base + new_off + HEAD;
        return bfla_pkg::ST_OK;
    endfunction

    function bit [1:0] release_block(bit [31:0] addr);
        bit [31:0] off;
        int        steps;
        bit        linked;
        hdr_t      cur, c, pre, nxt;
        if (!pool_up)
            return bfla_pkg::ST_INVALID;
        // range test without wrap
        if (longint'(addr) < longint'(pool_base) + HEAD ||
            longint'(addr) + HEAD > longint'(pool_base) + pool_bytes)
            return bfla_pkg::ST_FREEFAIL;
        off    = addr - pool_base - HEAD;
        linked = 0;
        steps  = 0;
        cur    = rd(0);
        while (steps < DEPTH + 2) begin
            if (cur.next == off) begin
                linked = 1;
                break;
            end
            if (cur.next == NONE)
                break;
            cur = rd(cur.next);
            steps++;
        end
        if (!linked)
            return bfla_pkg::ST_FREEFAIL;
        c = rd(off);
        if (c.prev == NONE || c.next == NONE)
            return bfla_pkg::ST_FREEFAIL;
        pre = rd(c.prev);
        nxt = rd(c.next);
        pre.next = c.next;
        nxt.prev = c.prev;
        wr(c.prev, pre);
        wr(c.next, nxt);
        return bfla_pkg::ST_OK;
    endfunction

    // Accepted item: predict and queue its outcome
    function void note_item(bit [1:0] cmd, bit [16:0] req, bit [31:0] addr,
                            output bit [1:0] st, output bit [31:0] grant);
        grant = 0;
        case (cmd)
            bfla_pkg::CMD_CREATE: st = create_pool();
            bfla_pkg::CMD_ALLOC:  st = best_fit(req, grant);
            bfla_pkg::CMD_FREE:   st = release_block(addr);
            default:              st = bfla_pkg::ST_INVALID;
        endcase
        if (st != bfla_pkg::ST_OK)
            grant = 0;
        status_q.push_back(st);
        grant_q.push_back(grant);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] grant);
        bit [1:0]  exp_st;
        bit [31:0] exp_grant;
        if (status_q.size() == 0) begin
            $display("%0t: result with nothing pending: status %0d grant %h",
                     $time, st, grant);
            errors++;
            return;
        end
        exp_st    = status_q.pop_front();
        exp_grant = grant_q.pop_front();
        checked++;
        if (st !== exp_st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_st, st);
            errors++;
        end
        if (grant !== exp_grant) begin
            $display("%0t: granted_address expected %h actual %h",
                     $time, exp_grant, grant);
            errors++;
        end
    endfunction

    function int pending();
        return status_q.size();
    endfunction
endclass

module best_fit_list_allocator_tb;
    import bfla_pkg::*;

    localparam int WATCHDOG = 40000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [16:0] request_bytes;
    logic [31:0] payload_address;
    logic        done;
    logic [1:0]  status;
    logic [31:0] granted_address;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    alloc_scoreboard sb;
    bit [31:0] live_q [$];
    bit [31:0] freed_q [$];
    bit [31:0] last_grant;
    int        burst_left;
    int        idle_cycles;
    int        n_create, n_alloc, n_free, n_grant, n_freed;

    best_fit_list_allocator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .request_bytes   (request_bytes),
        .payload_address (payload_address),
        .done            (done),
        .status          (status),
        .granted_address (granted_address),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Result checking
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(status, granted_address);
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d items pending", sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Send one item; leaves start high, gaps lower it
    task automatic push_item(bit [1:0] cmd, bit [16:0] req, bit [31:0] addr);
        bit [1:0]  st;
        bit [31:0] grant;
        int        k;
        start           <= 1'b1;
        command         <= cmd;
        request_bytes   <= req;
        payload_address <= addr;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(cmd, req, addr, st, grant);
        case (cmd)
            CMD_CREATE: n_create++;
            CMD_ALLOC:  n_alloc++;
            CMD_FREE:   n_free++;
            default: ;
        endcase
        if (cmd == CMD_CREATE && st == ST_OK)
            live_q.delete();
        if (cmd == CMD_ALLOC && st == ST_OK) begin
            live_q.push_back(grant);
            last_grant = grant;
            n_grant++;
        end
        if (cmd == CMD_FREE && st == ST_OK) begin
            n_freed++;
            for (k = 0; k < live_q.size(); k++)
                if (live_q[k] == addr) begin
                    live_q.delete(k);
                    break;
                end
            freed_q.push_back(addr);
            if (freed_q.size() > 16)
                void'(freed_q.pop_front());
        end
        // sender pacing: bursts with gaps
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
            k = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (k > 0) begin
                start <= 1'b0;
                repeat (k) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write, only while idle
    task automatic write_reg(logic idx, bit [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic bit [16:0] pick_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 17'($urandom_range(0, 64) * 8);
        else if (r < 80)
            return 17'($urandom_range(0, 8192) * 8);
        else if (r < 90)
            return 17'($urandom);
        else
            return 17'($urandom_range(0, 700) * 8);
    endfunction

    function automatic bit [31:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65 && live_q.size() > 0)
            return live_q[$urandom_range(0, live_q.size() - 1)];
        else if (r < 75 && freed_q.size() > 0)
            return freed_q[$urandom_range(0, freed_q.size() - 1)];
        else if (r < 85)
            return sb.pool_base + 32'($urandom_range(0, 8191) * 8);
        else
            return $urandom;
    endfunction

    initial
    begin
        int        ph;
        int        i;
        int        r;
        bit [31:0] b;
        bit [16:0] p;

        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_CREATE;
        request_bytes = '0;
        payload_address = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BASE;
        cfg_data = '0;
        burst_left = 10;
        idle_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: commands before the pool exists, unknown command
        push_item(CMD_ALLOC, 17'd16, 32'd0);
        push_item(CMD_FREE, 17'd0, 32'd16);
        push_item(2'd3, 17'h1FFFF, 32'hFFFF_FFFF);
        drain();

        // create checks: misaligned, too small, too large, then smallest pool
        write_reg(CFG_POOL, 32'd100);
        push_item(CMD_CREATE, 17'd0, 32'd0);
        drain();
        write_reg(CFG_POOL, 32'd24);
        push_item(CMD_CREATE, 17'd0, 32'd0);
        drain();
        write_reg(CFG_POOL, 32'h1FFFF);
        push_item(CMD_CREATE, 17'd0, 32'd0);
        push_item(CMD_ALLOC, 17'd0, 32'd0);
        drain();
        write_reg(CFG_POOL, 32'd32);
        push_item(CMD_CREATE, 17'd0, 32'd0);
        push_item(CMD_ALLOC, 17'd0, 32'd0);
        drain();

        // full pool near the top of the address space
        write_reg(CFG_POOL, 32'd65536);
        write_reg(CFG_BASE, 32'hFFFF_FFF0);
        push_item(CMD_CREATE, 17'd0, 32'd0);
        push_item(CMD_ALLOC, 17'd0, 32'd0);
        push_item(CMD_ALLOC, 17'd8, 32'd0);
        push_item(CMD_ALLOC, 17'd3, 32'd0);
        push_item(CMD_ALLOC, 17'd65536, 32'd0);
        push_item(CMD_ALLOC, 17'd65472, 32'd0);
        drain();
        write_reg(CFG_BASE, 32'd0);
        push_item(CMD_CREATE, 17'd0, 32'd0);
        push_item(CMD_ALLOC, 17'd64, 32'd0);
        push_item(CMD_ALLOC, 17'd0, 32'd0);
        push_item(CMD_FREE, 17'd0, last_grant);
        push_item(CMD_FREE, 17'd0, last_grant);
        push_item(CMD_FREE, 17'd0, 32'd8);
        push_item(CMD_FREE, 17'd0, 32'd65528);
        push_item(CMD_FREE, 17'd0, 32'd65520);
        drain();
        // tail becomes freeable by range once the pool grows after create
        write_reg(CFG_POOL, 32'd4096);
        push_item(CMD_CREATE, 17'd0, 32'd0);
        drain();
        write_reg(CFG_POOL, 32'd65536);
        push_item(CMD_FREE, 17'd0, 32'd4096);
        push_item(CMD_ALLOC, 17'd8, 32'd0);
        drain();

        // random phases over several pool settings
        for (ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                b = 32'hFFFF_FFFF;
                p = 17'd65536;
            end else if (ph == 7) begin
                b = 32'd0;
                p = 17'd32;
            end else begin
                r = $urandom_range(0, 9);
                b = (r < 3) ? 32'd0 : $urandom;
                p = (r == 9) ? 17'($urandom_range(32, 65536))
                  : (r < 5) ? 17'd65536 : 17'($urandom_range(4, 8192) * 8);
            end
            write_reg(CFG_BASE, b);
            write_reg(CFG_POOL, 32'(p));
            if (ph == 0 || $urandom_range(0, 5) != 0)
                push_item(CMD_CREATE, 17'd0, 32'd0);
            for (i = 0; i < 140; i++) begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    push_item(CMD_ALLOC, pick_request(), $urandom);
                else if (r < 95)
                    push_item(CMD_FREE, 17'($urandom), pick_address());
                else if (r < 98)
                    push_item(CMD_CREATE, 17'($urandom), $urandom);
                else
                    push_item(2'd3, 17'($urandom), $urandom);
            end
            drain();
        end

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d creates, %0d allocates (%0d granted), %0d frees (%0d done)",
                 n_create, n_alloc, n_grant, n_free, n_freed);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
